// ===== design/rwd_pkg.sv =====
package rwd_pkg;

    localparam int unsigned WordWidth = 32;
    localparam int unsigned OutDataWidth = 152;

    typedef enum logic [2:0] {
        KIND_BLKHDR  = 3'd0,
        KIND_BLKTLR  = 3'd1,
        KIND_EVTHDR  = 3'd2,
        KIND_STAMP   = 3'd3,
        KIND_HIT     = 3'd4,
        KIND_INVALID = 3'd5,
        KIND_TYPEERR = 3'd6
    } kind_t;

    localparam logic [3:0] TYPE_BLKHDR  = 4'h0;
    localparam logic [3:0] TYPE_BLKTLR  = 4'h1;
    localparam logic [3:0] TYPE_EVTHDR  = 4'h2;
    localparam logic [3:0] TYPE_TRIGTM  = 4'h3;
    localparam logic [3:0] TYPE_HIT     = 4'h8;
    localparam logic [3:0] TYPE_INVALID = 4'hE;
    localparam logic [3:0] TYPE_FILLER  = 4'hF;

    typedef struct packed {
        logic        stamp_pending;
        logic [23:0] stamp_high;
        logic [4:0]  current_slot;
        logic        event_stopped;
    } rwd_state_t;

    typedef struct packed {
        kind_t       kind;
        logic [4:0]  slot;
        logic [6:0]  channel;
        logic [15:0] tdc;
        logic [26:0] event_number;
        logic [10:0] event_count;
        logic [10:0] block_number;
        logic [21:0] word_count;
        logic [47:0] timestamp;
    } rwd_result_t;

endpackage

// ===== design/rwd_decode.sv =====
module rwd_decode (
    input  logic [rwd_pkg::WordWidth-1:0] data_word,
    input  logic                          event_start,
    input  rwd_pkg::rwd_state_t           state_cur,
    output rwd_pkg::rwd_state_t           state_next,
    output rwd_pkg::rwd_result_t          result,
    output logic                          has_result
);
    import rwd_pkg::*;

    logic       pending_eff;
    logic       stopped_eff;
    logic [3:0] word_type;

    assign pending_eff = state_cur.stamp_pending & ~event_start;
    assign stopped_eff = state_cur.event_stopped & ~event_start;
    assign word_type   = data_word[30:27];

    always_comb begin
        state_next               = state_cur;
        state_next.stamp_pending = pending_eff;
        state_next.event_stopped = stopped_eff;
        result                   = '0;
        has_result               = 1'b0;
        if (stopped_eff) begin
            has_result = 1'b0;
        end else if (pending_eff) begin
            state_next.stamp_pending = 1'b0;
            has_result               = 1'b1;
            result.kind              = KIND_STAMP;
            result.timestamp         = {state_cur.stamp_high, data_word[23:0]};
        end else if (data_word[31]) begin
            unique case (word_type)
                TYPE_BLKHDR: begin
                    state_next.current_slot = data_word[26:22];
                    has_result              = 1'b1;
                    result.kind             = KIND_BLKHDR;
                    result.slot             = data_word[26:22];
                    result.event_count      = data_word[21:11];
                    result.block_number     = data_word[10:0];
                end
                TYPE_BLKTLR: begin
                    has_result        = 1'b1;
                    result.kind       = KIND_BLKTLR;
                    result.slot       = data_word[26:22];
                    result.word_count = data_word[21:0];
                end
                TYPE_EVTHDR: begin
                    has_result          = 1'b1;
                    result.kind         = KIND_EVTHDR;
                    result.event_number = data_word[26:0];
                end
                TYPE_TRIGTM: begin
                    state_next.stamp_high    = data_word[23:0];
                    state_next.stamp_pending = 1'b1;
                end
                TYPE_HIT: begin
                    has_result     = 1'b1;
                    result.kind    = KIND_HIT;
                    result.slot    = state_cur.current_slot;
                    result.channel = data_word[22:16];
                    result.tdc     = data_word[15:0];
                end
                TYPE_INVALID: begin
                    state_next.event_stopped = 1'b1;
                    has_result               = 1'b1;
                    result.kind              = KIND_INVALID;
                end
                TYPE_FILLER: begin
                    has_result = 1'b0;
                end
                default: begin
                    state_next.event_stopped = 1'b1;
                    has_result               = 1'b1;
                    result.kind              = KIND_TYPEERR;
                end
            endcase
        end
    end

endmodule

// ===== design/readout_word_decoder.sv =====
// channel | dir | tdata                                   | tuser
// s_      | in  | data_word[31:0]                         | event_start
// m_      | out | slot,channel,tdc,event_number,          | kind[2:0]
//         |     | event_count,block_number,word_count,    |
//         |     | timestamp (zero pad to 152 bits)        |
// One word per cycle sustained while m_ is not stalled; a taken word passes the input register,
// then the decode logic, then the result register.
// Reset clears the decode state and both valid flags.
// A stall on m_ holds the result register; words that give no result still drain.
module readout_word_decoder (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [rwd_pkg::WordWidth-1:0]    s_tdata,  // data_word[31:0]
    input  logic [0:0]                       s_tuser,  // event_start
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // slot[4:0] channel[11:5] tdc[27:12] event_number[54:28] event_count[65:55]
    // block_number[76:66] word_count[98:77] timestamp[146:99] zero[151:147]
    output logic [rwd_pkg::OutDataWidth-1:0] m_tdata,
    output logic [2:0]                       m_tuser   // kind[2:0]
);
    import rwd_pkg::*;

    logic                 in_valid_reg;
    logic                 in_valid_next;
    logic [WordWidth-1:0] in_word_reg;
    logic                 in_start_reg;
    rwd_state_t           state_reg;
    rwd_state_t           state_next;
    rwd_result_t          dec_result;
    logic                 dec_has;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    rwd_result_t          out_result_reg;
    logic                 out_free;
    logic                 in_moves;
    logic                 out_load;

    rwd_decode u_decode (
        .data_word   (in_word_reg),
        .event_start (in_start_reg),
        .state_cur   (state_reg),
        .state_next  (state_next),
        .result      (dec_result),
        .has_result  (dec_has)
    );

    assign out_free = ~out_valid_reg | m_tready;
    assign in_moves = in_valid_reg & (~dec_has | out_free);
    assign out_load = in_moves & dec_has;
    assign s_tready = ~in_valid_reg | in_moves;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_tvalid && s_tready) begin
            in_valid_next = 1'b1;
        end else if (in_moves) begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (out_load) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (in_moves) begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_word_reg  <= s_tdata;
            in_start_reg <= s_tuser[0];
        end
        if (out_load) begin
            out_result_reg <= dec_result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_result_reg.kind;
    assign m_tdata  = {5'd0,
                       out_result_reg.timestamp,
                       out_result_reg.word_count,
                       out_result_reg.block_number,
                       out_result_reg.event_count,
                       out_result_reg.event_number,
                       out_result_reg.tdc,
                       out_result_reg.channel,
                       out_result_reg.slot};

`ifndef ASSERT_OFF
    a_reset_clears_out: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    a_stamp_only_stamp: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser != KIND_STAMP) |-> (out_result_reg.timestamp == 48'd0))
        else $error("timestamp set on non-timestamp result");

    a_stamp_consumed: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_moves && state_reg.stamp_pending && !in_start_reg && !state_reg.event_stopped)
        |=> (!state_reg.stamp_pending && out_valid_reg
             && out_result_reg.kind == KIND_STAMP))
        else $error("pending stamp not delivered");

    a_stopped_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && state_reg.event_stopped && !in_start_reg) |-> !dec_has)
        else $error("result from stopped event");
`endif

endmodule
